/* src/power_iteration_dominant_eigen_assert.svh */
// Assertion macros for the dominant eigenvalue block
`ifndef POWER_ITERATION_DOMINANT_EIGEN_ASSERT_SVH
`define POWER_ITERATION_DOMINANT_EIGEN_ASSERT_SVH
`define PIDE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PIDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/pide_pkg.sv */
// Package with constants, types and helpers for the dominant eigenvalue block
package pide_pkg;
   localparam int MAX_ORDER_DEF = 8;
   localparam int FRACTION_BITS_DEF = 16;
   localparam logic [1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [1:0] STATUS_CAP = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;
   localparam logic [1:0] CSR_ORDER = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [1:0] CSR_CAP = 2'd2;
   typedef struct packed {
      logic start;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } div_req_type;
endpackage

/* src/pide_div.sv */
// Radix-2 signed divider computing (num << FRAC) / den truncated toward zero
module pide_div #(
   parameter int FRACTION_BITS = pide_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  pide_pkg::div_req_type req,
   output logic done,
   output logic signed [31:0] quot
);
   localparam int NB = 32 + FRACTION_BITS;
   localparam int CW = $clog2(NB + 1);
   logic [NB-1:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [33:0] sh;
   logic [33:0] diff;
   logic [NB-1:0] qn;
   logic [31:0] na, da;

   always_comb begin
      na = req.num[31] ? 32'(-req.num) : 32'(req.num);
      da = req.den[31] ? 32'(-req.den) : 32'(req.den);
      sh = {r_ff, q_ff[NB-1]};
      diff = sh - {2'b0, d_ff};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff;
      done = 1'b0;
      qn = neg_ff ? NB'(-q_ff) : q_ff;
      quot = qn[31:0];
      if (req.start) begin
         q_in = {na, {FRACTION_BITS{1'b0}}};
         r_in = '0; d_in = da;
         neg_in = req.num[31] ^ req.den[31];
         busy_in = 1'b1; cnt_in = CW'(NB);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0; done = 1'b1;
         end else begin
            if (!diff[33]) begin
               r_in = diff[32:0]; q_in = {q_ff[NB-2:0], 1'b1};
            end else begin
               r_in = sh[32:0]; q_in = {q_ff[NB-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end
endmodule

/* src/pide_mac.sv */
// Shared multiply-accumulate unit with Q rounding and saturation
module pide_mac #(
   parameter int FRACTION_BITS = pide_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic clear,
   input  logic enable,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic signed [31:0] result
);
   logic signed [63:0] prod_ff, prod_in;
   logic pv_ff, pv_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] term;

   always_comb begin
      prod_in = 64'(a) * 64'(b);
      pv_in = enable;
      term = (prod_ff + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      acc_in = clear ? 64'sd0 : (pv_ff ? acc_ff + term : acc_ff);
      if (acc_ff > 64'sd2147483647) result = 32'sh7fffffff;
      else if (acc_ff < -64'sd2147483648) result = 32'sh80000000;
      else result = acc_ff[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pv_ff <= clear ? 1'b0 : pv_in;
      acc_ff <= acc_in;
   end
endmodule

/* src/power_iteration_dominant_eigen.sv */
// Dominant eigenvalue by the power method: load, iterate, emit.
// Load: one element accepted per cycle; the store holds order*order elements.
// Solve: per pass, a MAC of each matrix row with the vector, then a division of each component;
// at most iteration_cap passes, fewer on convergence or a zero eigenvalue.
// Emit: n result transactions, one per cycle when not stalled; input stalls meanwhile.
// Reset: synchronous active high; order 3, tolerance 66, cap 1000, load count cleared.
`include "power_iteration_dominant_eigen_assert.svh"
module power_iteration_dominant_eigen #(
   parameter int MAX_ORDER = pide_pkg::MAX_ORDER_DEF,
   parameter int FRACTION_BITS = pide_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_element_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_component_index,
   output logic signed [31:0] rsp_vector_component,
   output logic signed [31:0] rsp_eigen_value,
   output logic [15:0] rsp_passes_done,
   output logic [1:0] rsp_status,
   output logic rsp_last_component,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
   localparam int NW = $clog2(MAX_ORDER + 1);
   localparam int EW = $clog2(MAX_ORDER * MAX_ORDER + 1);
   localparam logic [31:0] ONE_Q = 32'(1) << FRACTION_BITS;
   localparam logic [2:0] S_LOAD = 3'd0, S_INIT = 3'd1, S_MAC = 3'd2, S_ROW = 3'd3,
      S_DIV = 3'd4, S_DWAIT = 3'd5, S_CHECK = 3'd6, S_EMIT = 3'd7;

   logic [3:0] order_ff, order_in;
   logic [30:0] tol_ff, tol_in;
   logic [15:0] cap_ff, cap_in;
   logic [2:0] st_ff, st_in;
   logic [EW-1:0] ecnt_ff, ecnt_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [NW-1:0] k_ff, k_in;
   logic [2:0] wait_ff, wait_in;
   logic [15:0] pass_ff, pass_in;
   logic signed [31:0] lam_ff, lam_in;
   logic [32:0] best_ff, best_in;
   logic [32:0] err_ff, err_in;
   logic [1:0] status_ff, status_in;
   logic signed [31:0] cur_ff [MAX_ORDER];
   logic signed [31:0] prv_ff [MAX_ORDER];
   logic signed [31:0] prod_ff [MAX_ORDER];
   logic signed [31:0] mem [MAX_ORDER * MAX_ORDER];
   logic signed [31:0] mrd_ff;
   logic [AW-1:0] raddr;
   logic [NW-1:0] n;
   logic [15:0] cap_use;
   logic mac_clear, mac_en;
   logic signed [31:0] mac_res, xj_ff;
   pide_pkg::div_req_type dreq;
   logic ddone;
   logic signed [31:0] dq;
   logic [32:0] mag_res, dmag;
   logic signed [32:0] dd;
   logic in_acc, csr_acc;

   assign n = (order_ff == 4'd0) ? NW'(1) :
      ((32'(order_ff) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_ff));
   assign cap_use = (cap_ff == 16'd0) ? 16'd1 : cap_ff;
   assign req_stall = (st_ff != S_LOAD);
   assign csr_ready = 1'b1;
   assign in_acc = req_valid && !req_stall;
   assign csr_acc = csr_valid && csr_ready;
   assign raddr = AW'(32'(i_ff) * 32'(n) + 32'(j_ff));
   assign mag_res = mac_res[31] ? 33'(-34'(mac_res)) : 33'(mac_res);
   assign dd = 33'(prv_ff[i_ff]) - 33'(dq);
   assign dmag = dd[32] ? 33'(-dd) : 33'(dd);

   pide_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
      .clock(clock), .clear(mac_clear), .enable(mac_en),
      .a(mrd_ff), .b(xj_ff), .result(mac_res));
   pide_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock(clock), .reset(reset), .req(dreq), .done(ddone), .quot(dq));

   always_ff @(posedge clock) begin
      if (in_acc && ecnt_ff < EW'(MAX_ORDER * MAX_ORDER))
         mem[AW'(ecnt_ff)] <= req_element_value;
      mrd_ff <= mem[raddr];
      xj_ff <= prv_ff[j_ff];
   end

   always_comb begin
      order_in = order_ff; tol_in = tol_ff; cap_in = cap_ff;
      st_in = st_ff; ecnt_in = ecnt_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      wait_in = wait_ff; pass_in = pass_ff; lam_in = lam_ff; best_in = best_ff;
      err_in = err_ff; status_in = status_ff;
      mac_clear = 1'b0; mac_en = 1'b0;
      dreq = '{start: 1'b0, num: prod_ff[i_ff], den: lam_ff};
      case (st_ff)
         S_LOAD: begin
            if (in_acc) begin
               if (32'(ecnt_ff) + 1 >= 32'(n) * 32'(n)) begin
                  ecnt_in = '0; st_in = S_INIT; pass_in = '0;
               end else ecnt_in = ecnt_ff + 1'b1;
            end
         end
         S_INIT: begin
            i_in = '0; j_in = '0; wait_in = '0; mac_clear = 1'b1; st_in = S_MAC;
         end
         S_MAC: begin
            if (wait_ff == 3'd0) begin
               wait_in = 3'd1;
            end else begin
               mac_en = 1'b1; wait_in = 3'd0;
               if (32'(j_ff) + 1 >= 32'(n)) begin
                  st_in = S_ROW; wait_in = '0;
               end else j_in = j_ff + 1'b1;
            end
         end
         S_ROW: begin
            if (wait_ff < 3'd2) wait_in = wait_ff + 1'b1;
            else begin
               if (i_ff == '0 || mag_res > best_ff) begin
                  best_in = mag_res; lam_in = mac_res;
               end
               mac_clear = 1'b1; j_in = '0; wait_in = '0;
               if (32'(i_ff) + 1 >= 32'(n)) begin
                  i_in = '0; st_in = S_DIV; pass_in = pass_ff + 1'b1; err_in = '0;
               end else begin
                  i_in = i_ff + 1'b1; st_in = S_MAC;
               end
            end
         end
         S_DIV: begin
            if (lam_ff == 32'sd0) begin
               status_in = pide_pkg::STATUS_ZERO; st_in = S_EMIT; k_in = '0;
            end else begin
               dreq.start = 1'b1; st_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (ddone) begin
               if (dmag > err_ff) err_in = dmag;
               if (32'(i_ff) + 1 >= 32'(n)) st_in = S_CHECK;
               else begin
                  i_in = i_ff + 1'b1; st_in = S_DIV;
               end
            end
         end
         S_CHECK: begin
            i_in = '0;
            if (err_ff <= 33'(tol_ff)) begin
               status_in = pide_pkg::STATUS_CONVERGED; st_in = S_EMIT; k_in = '0;
            end else if (pass_ff >= cap_use) begin
               status_in = pide_pkg::STATUS_CAP; st_in = S_EMIT; k_in = '0;
            end else st_in = S_INIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (32'(k_ff) + 1 >= 32'(n)) st_in = S_LOAD;
               else k_in = k_ff + 1'b1;
            end
         end
         default: st_in = S_LOAD;
      endcase
      if (csr_acc) begin
         case (csr_index)
            pide_pkg::CSR_ORDER: begin
               order_in = csr_data[3:0]; ecnt_in = '0;
            end
            pide_pkg::CSR_TOLERANCE: tol_in = csr_data[30:0];
            pide_pkg::CSR_CAP: cap_in = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 4'd3; tol_ff <= 31'd66; cap_ff <= 16'd1000;
         st_ff <= S_LOAD; ecnt_ff <= '0; pass_ff <= '0;
      end else begin
         order_ff <= order_in; tol_ff <= tol_in; cap_ff <= cap_in;
         st_ff <= st_in; ecnt_ff <= ecnt_in; pass_ff <= pass_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; wait_ff <= wait_in;
      lam_ff <= lam_in; best_ff <= best_in; err_ff <= err_in; status_ff <= status_in;
      if (st_ff == S_LOAD && st_in == S_INIT) begin
         for (int q = 0; q < MAX_ORDER; q++) cur_ff[q] <= ONE_Q;
      end
      if (st_ff == S_INIT) begin
         for (int q = 0; q < MAX_ORDER; q++) prv_ff[q] <= cur_ff[q];
      end
      if (st_ff == S_ROW && wait_ff == 3'd2) begin
         prod_ff[i_ff] <= mac_res;
         cur_ff[i_ff] <= mac_res;
      end
      if (st_ff == S_DWAIT && ddone) cur_ff[i_ff] <= dq;
   end

   assign rsp_valid = (st_ff == S_EMIT);
   assign rsp_component_index = 3'(k_ff);
   assign rsp_vector_component = cur_ff[IW'(k_ff)];
   assign rsp_eigen_value = lam_ff;
   assign rsp_passes_done = pass_ff;
   assign rsp_status = status_ff;
   assign rsp_last_component = (32'(k_ff) + 1 >= 32'(n));

   `PIDE_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_valid, req_stall)
   `PIDE_ASSERT_IMPL(a_pass_cap, clock, reset, rsp_valid, pass_ff <= cap_use)
   `PIDE_ASSERT_NEXT(a_last_done, clock, reset,
      rsp_valid && !rsp_stall && rsp_last_component, !rsp_valid)
endmodule
